// File: sv/dtot_pkg.sv
// Shared types and constants for the device time offset table.
`timescale 1ns / 1ps
package dtot_pkg;

	localparam int MAX_DEVICES = 16;
	localparam int IDX_W       = (MAX_DEVICES > 1) ? $clog2(MAX_DEVICES) : 1;
	localparam int CNT_W       = 5;

	localparam logic [2:0] ACT_UPDATE  = 3'd0;
	localparam logic [2:0] ACT_SET_REF = 3'd1;
	localparam logic [2:0] ACT_CALC    = 3'd2;
	localparam logic [2:0] ACT_GET     = 3'd3;
	localparam logic [2:0] ACT_TIMEOUT = 3'd4;

	localparam logic [2:0] ST_OK       = 3'd0;
	localparam logic [2:0] ST_NOT_FND  = 3'd1;
	localparam logic [2:0] ST_FULL     = 3'd2;
	localparam logic [2:0] ST_NO_REF   = 3'd3;
	localparam logic [2:0] ST_REF_IDLE = 3'd4;

	localparam logic [63:0] SIGN64 = 64'h8000_0000_0000_0000;

	typedef struct packed {
		logic [31:0] id;
		logic [63:0] ts;
		logic [63:0] offset;
		logic [31:0] seen;
	} entry_t;

	typedef struct packed {
		logic             en;
		logic [IDX_W-1:0] addr;
		entry_t           data;
	} mem_wr_t;

endpackage

// File: sv/dtot_req_if.sv
// Request channel: one table action per transaction.
`timescale 1ns / 1ps
interface dtot_req_if;
	logic        valid;
	logic        ready;
	logic [2:0]  action;
	logic [31:0] dev_id;
	logic [63:0] dev_time_us;
	logic [31:0] now_seconds;

	modport source (output valid, action, dev_id, dev_time_us, now_seconds, input ready);
	modport sink (input valid, action, dev_id, dev_time_us, now_seconds, output ready);
endinterface

// File: sv/dtot_rsp_if.sv
// Response channel: one result per request transaction.
`timescale 1ns / 1ps
interface dtot_rsp_if;
	logic               valid;
	logic               ready;
	logic [2:0]         status;
	logic signed [63:0] offset_us;
	logic signed [63:0] off_max;
	logic signed [63:0] off_min;
	logic signed [63:0] off_mean;
	logic [4:0]         live_count;
	logic [4:0]         entry_count;
	logic [4:0]         timeouts_found;
	logic [31:0]        calc_cycles;

	modport source (output valid, status, offset_us, off_max, off_min,
		off_mean, live_count, entry_count, timeouts_found, calc_cycles,
		input ready);
	modport sink (input valid, status, offset_us, off_max, off_min,
		off_mean, live_count, entry_count, timeouts_found, calc_cycles,
		output ready);
endinterface

// File: sv/device_time_offset_table_core.sv
// Device time offset table: sequencer over the entry memory, stats and response register.
//
//  channel | dir | handshake        | carries
//  req     | in  | valid/ready      | action, dev_id, dev_time_us, now_seconds
//  rsp     | out | valid/ready      | status, offsets, counts, calc_cycles
//  cfg     | in  | cfg_we           | timeout_seconds (cfg_wdata)
//
// One transaction at a time. Every entry visit runs a memory read state, then an evaluate state.
// Update, set-reference, get-offset: the scan stops at the entry that hits, or covers all n
// entries on a miss. Timeout check: always scans all n entries.
// Calculate: a pass to find the reference, a pass over all entries, then the 64-step divider if needed.
// req is ready the cycle after the response loads; the output stage holds while rsp waits.
// arst_n clears the fill count and flags; no memory clearing pass is needed.
`timescale 1ns / 1ps
module device_time_offset_table_core (
	input  logic        clk,
	input  logic        arst_n,
	dtot_req_if.sink    req,
	dtot_rsp_if.source  rsp,
	input  logic        cfg_we,
	input  logic [15:0] cfg_wdata
);
	localparam int IW = dtot_pkg::IDX_W;
	localparam int CW = dtot_pkg::CNT_W;
	localparam logic [CW-1:0] MAX_CNT = CW'(dtot_pkg::MAX_DEVICES);

	typedef enum logic [2:0] {S_IDLE, S_RD, S_EV, S_DIV, S_OUT} state_t;

	state_t state_q;
	logic [2:0]  op_q;
	logic [31:0] id_q;
	logic [63:0] ts_q;
	logic [31:0] now_q;
	logic [CW-1:0] idx_q, used_q;
	logic        pass_q;
	logic [31:0] ref_q;
	logic [dtot_pkg::MAX_DEVICES-1:0] act_q;
	logic [15:0] tmo_q;
	logic [63:0] st_max_q, st_min_q, st_avg_q, mx_q, mn_q, sum_q, ref_ts_q, off_q;
	logic [CW-1:0] st_act_q, cnt_q, others_q, touts_q;
	logic [31:0] cyc_q;
	logic [2:0]  status_q;
	logic        neg_q;

	dtot_pkg::mem_wr_t wr;
	dtot_pkg::entry_t  e;
	logic        scan_end, hit, act_i, div_done, div_start;
	logic [63:0] offv, quot, div_in;
	logic [31:0] age;
	logic        tmo_hit;

	assign scan_end = idx_q == used_q;
	assign hit      = e.id == id_q;
	assign act_i    = act_q[idx_q[IW-1:0]];
	assign offv     = hit ? 64'd0 : ref_ts_q - e.ts;
	assign age      = now_q - e.seen;
	assign tmo_hit  = act_i && (now_q >= e.seen) && (age > {16'd0, tmo_q});
	assign div_start = state_q == S_RD && scan_end && op_q == dtot_pkg::ACT_CALC && pass_q
		&& others_q != '0;
	assign div_in   = sum_q[63] ? 64'd0 - sum_q : sum_q;

	always_comb begin
		wr      = '0;
		wr.addr = idx_q[IW-1:0];
		if (state_q == S_RD && scan_end && op_q == dtot_pkg::ACT_UPDATE
			&& used_q != MAX_CNT) begin
			wr.en   = 1'b1;
			wr.addr = used_q[IW-1:0];
			wr.data = '{id: id_q, ts: ts_q, offset: 64'd0, seen: now_q};
		end else if (state_q == S_EV && op_q == dtot_pkg::ACT_UPDATE && hit) begin
			wr.en   = 1'b1;
			wr.data = '{id: e.id, ts: ts_q, offset: e.offset, seen: now_q};
		end else if (state_q == S_EV && op_q == dtot_pkg::ACT_CALC && pass_q && act_i) begin
			wr.en   = 1'b1;
			wr.data = '{id: e.id, ts: e.ts, offset: offv, seen: e.seen};
		end
	end

	dtot_mem u_mem (
		.clk     (clk),
		.wr      (wr),
		.rd_addr (idx_q[IW-1:0]),
		.rd_data (e)
	);

	dtot_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_in),
		.divisor  (others_q),
		.done     (div_done),
		.quotient (quot)
	);

	assign req.ready = state_q == S_IDLE;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			used_q    <= '0;
			ref_q     <= '0;
			act_q     <= '0;
			tmo_q     <= 16'd5;
			st_max_q  <= '0;
			st_min_q  <= '0;
			st_avg_q  <= '0;
			st_act_q  <= '0;
			cyc_q     <= '0;
			rsp.valid <= 1'b0;
		end else begin
			if (cfg_we) begin
				tmo_q <= cfg_wdata;
			end
			if (rsp.valid && rsp.ready && state_q != S_OUT) begin
				rsp.valid <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (req.valid) begin
						op_q     <= req.action;
						id_q     <= req.action == dtot_pkg::ACT_CALC ? ref_q : req.dev_id;
						ts_q     <= req.dev_time_us;
						now_q    <= req.now_seconds;
						idx_q    <= '0;
						pass_q   <= 1'b0;
						status_q <= dtot_pkg::ST_OK;
						off_q    <= '0;
						touts_q  <= '0;
						mx_q     <= dtot_pkg::SIGN64;
						mn_q     <= ~dtot_pkg::SIGN64;
						sum_q    <= '0;
						others_q <= '0;
						cnt_q    <= '0;
						case (req.action)
							dtot_pkg::ACT_UPDATE, dtot_pkg::ACT_SET_REF, dtot_pkg::ACT_GET,
							dtot_pkg::ACT_TIMEOUT: state_q <= S_RD;
							dtot_pkg::ACT_CALC: begin
								if (ref_q == '0) begin
									status_q <= dtot_pkg::ST_NO_REF;
									state_q  <= S_OUT;
								end else begin
									state_q <= S_RD;
								end
							end
							default: state_q <= S_OUT;
						endcase
					end
				end
				S_RD: begin
					if (!scan_end) begin
						state_q <= S_EV;
					end else begin
						state_q <= S_OUT;
						case (op_q)
							dtot_pkg::ACT_UPDATE: begin
								if (used_q == MAX_CNT) begin
									status_q <= dtot_pkg::ST_FULL;
								end else begin
									act_q[used_q[IW-1:0]] <= 1'b1;
									used_q <= used_q + CW'(1);
									if (ref_q == '0 && id_q != '0) begin
										ref_q <= id_q;
									end
								end
							end
							dtot_pkg::ACT_SET_REF, dtot_pkg::ACT_GET:
								status_q <= dtot_pkg::ST_NOT_FND;
							dtot_pkg::ACT_CALC: begin
								if (!pass_q) begin
									status_q <= dtot_pkg::ST_REF_IDLE;
								end else begin
									st_act_q <= cnt_q;
									if (others_q == '0) begin
										st_max_q <= '0;
										st_min_q <= '0;
										st_avg_q <= '0;
										cyc_q    <= cyc_q + 32'd1;
									end else begin
										st_max_q <= mx_q;
										st_min_q <= mn_q;
										neg_q    <= sum_q[63];
										state_q  <= S_DIV;
									end
								end
							end
							default: ;
						endcase
					end
				end
				S_EV: begin
					state_q <= S_RD;
					idx_q   <= idx_q + CW'(1);
					case (op_q)
						dtot_pkg::ACT_UPDATE: begin
							if (hit) begin
								act_q[idx_q[IW-1:0]] <= 1'b1;
								state_q <= S_OUT;
							end
						end
						dtot_pkg::ACT_SET_REF: begin
							if (hit) begin
								ref_q   <= id_q;
								state_q <= S_OUT;
							end
						end
						dtot_pkg::ACT_GET: begin
							if (hit) begin
								off_q   <= e.offset;
								state_q <= S_OUT;
							end
						end
						dtot_pkg::ACT_CALC: begin
							if (!pass_q) begin
								if (hit) begin
									if (!act_i) begin
										status_q <= dtot_pkg::ST_REF_IDLE;
										state_q  <= S_OUT;
									end else begin
										ref_ts_q <= e.ts;
										pass_q   <= 1'b1;
										idx_q    <= '0;
									end
								end
							end else if (act_i) begin
								cnt_q <= cnt_q + CW'(1);
								if (!hit) begin
									if ($signed(offv) > $signed(mx_q)) mx_q <= offv;
									if ($signed(offv) < $signed(mn_q)) mn_q <= offv;
									sum_q    <= sum_q + offv;
									others_q <= others_q + CW'(1);
								end
							end
						end
						dtot_pkg::ACT_TIMEOUT: begin
							if (tmo_hit) begin
								act_q[idx_q[IW-1:0]] <= 1'b0;
								touts_q <= touts_q + CW'(1);
							end
						end
						default: state_q <= S_OUT;
					endcase
				end
				S_DIV: begin
					if (div_done) begin
						st_avg_q <= neg_q ? 64'd0 - quot : quot;
						cyc_q    <= cyc_q + 32'd1;
						state_q  <= S_OUT;
					end
				end
				S_OUT: begin
					if (!rsp.valid || rsp.ready) begin
						rsp.valid          <= 1'b1;
						rsp.status         <= status_q;
						rsp.offset_us      <= off_q;
						rsp.off_max        <= st_max_q;
						rsp.off_min        <= st_min_q;
						rsp.off_mean       <= st_avg_q;
						rsp.live_count     <= st_act_q;
						rsp.entry_count    <= used_q;
						rsp.timeouts_found <= touts_q;
						rsp.calc_cycles    <= cyc_q;
						state_q            <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	a_used_bound: assert property (@(posedge clk) disable iff (!arst_n)
		used_q <= MAX_CNT)
		else $error("fill count beyond table size");

	a_idx_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_EV |-> idx_q < used_q)
		else $error("evaluating an unfilled entry");

	a_act_filled: assert property (@(posedge clk) disable iff (!arst_n)
		(act_q >> used_q) == '0)
		else $error("active flag set on unfilled entry");

	a_div_ends: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> state_q == S_DIV)
		else $error("divider finished outside divide state");
endmodule

// File: sv/dtot_mem.sv
// Entry memory: one write port, one read port with registered read data.
`timescale 1ns / 1ps
module dtot_mem (
	input  logic                     clk,
	input  dtot_pkg::mem_wr_t        wr,
	input  logic [dtot_pkg::IDX_W-1:0] rd_addr,
	output dtot_pkg::entry_t         rd_data
);
	dtot_pkg::entry_t mem [dtot_pkg::MAX_DEVICES];

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr] <= wr.data;
		end
		rd_data <= mem[rd_addr];
	end
endmodule

// File: sv/dtot_div.sv
// Restoring divider, one quotient bit per cycle, 64-bit dividend by small divisor.
`timescale 1ns / 1ps
module dtot_div (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [63:0]                dividend,
	input  logic [dtot_pkg::CNT_W-1:0] divisor,
	output logic                       done,
	output logic [63:0]                quotient
);
	logic [63:0]                q_q;
	logic [dtot_pkg::CNT_W:0]   rem_q;
	logic [dtot_pkg::CNT_W-1:0] d_q;
	logic [6:0]                 cnt_q;
	logic                       run_q;
	logic                       done_q;
	logic [dtot_pkg::CNT_W:0]   rem_sh;
	logic                       ge;

	assign rem_sh = {rem_q[dtot_pkg::CNT_W-1:0], q_q[63]};
	assign ge     = rem_sh >= {1'b0, d_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + 7'd1;
				if (cnt_q == 7'd63) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			q_q   <= dividend;
			rem_q <= '0;
			d_q   <= divisor;
		end else if (run_q) begin
			q_q   <= {q_q[62:0], ge};
			rem_q <= ge ? rem_sh - {1'b0, d_q} : rem_sh;
		end
	end

	assign done     = done_q;
	assign quotient = q_q;
endmodule

// File: tb/dtot_tb_if.sv
// Testbench item types for the request and response channels.
`timescale 1ns / 1ps
package dtot_tb_pkg;

	typedef struct packed {
		logic [2:0]  action;
		logic [31:0] dev_id;
		logic [63:0] dev_time_us;
		logic [31:0] now_seconds;
	} dtot_req_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [63:0] offset_us;
		logic [63:0] off_max;
		logic [63:0] off_min;
		logic [63:0] off_mean;
		logic [4:0]  live_count;
		logic [4:0]  entry_count;
		logic [4:0]  timeouts_found;
		logic [31:0] calc_cycles;
	} dtot_rsp_t;
endpackage

// File: tb/tb_top.sv
// Self-checking testbench for the device time offset table core.
`timescale 1ns / 1ps
module tb_top;

	localparam int STALL_LIMIT = 20000;
	localparam int DRAIN_CYCLES = 300;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [15:0] cfg_wdata;

	dtot_req_if req ();
	dtot_rsp_if rsp ();

	device_time_offset_table_core i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req.sink),
		.rsp       (rsp.source),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	// shadow of the device table
	logic [31:0] tbl_id   [dtot_pkg::MAX_DEVICES];
	logic [63:0] tbl_ts   [dtot_pkg::MAX_DEVICES];
	logic [63:0] tbl_off  [dtot_pkg::MAX_DEVICES];
	logic        tbl_act  [dtot_pkg::MAX_DEVICES];
	logic [31:0] tbl_seen [dtot_pkg::MAX_DEVICES];
	int          tbl_used;
	logic [31:0] ref_dev;
	logic [63:0] s_max, s_min, s_avg;
	logic [4:0]  s_active;
	logic [31:0] s_cycles;
	logic [15:0] timeout_lim;

	dtot_tb_pkg::dtot_req_t pending_reqs[$];
	dtot_tb_pkg::dtot_rsp_t expected_rsps[$];
	int  errors;
	int  stall_cnt;
	bit  quiet;
	bit  req_fire;
	int  req_gap, rsp_gap;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic int find_dev(logic [31:0] id);
		for (int i = 0; i < tbl_used; i++)
			if (tbl_id[i] == id) return i;
		return -1;
	endfunction

	function automatic dtot_tb_pkg::dtot_rsp_t table_apply(dtot_tb_pkg::dtot_req_t r);
		dtot_tb_pkg::dtot_rsp_t o;
		int k;
		int act_n, others;
		logic [63:0] rts, off, mx, mn, sum, q;
		o = '0;
		case (r.action)
			dtot_pkg::ACT_UPDATE: begin
				k = find_dev(r.dev_id);
				if (k < 0 && tbl_used >= dtot_pkg::MAX_DEVICES) begin
					o.status = dtot_pkg::ST_FULL;
				end else begin
					if (k < 0) begin
						k = tbl_used;
						tbl_used++;
						tbl_id[k] = r.dev_id;
						tbl_off[k] = '0;
						if (ref_dev == 0 && r.dev_id != 0) ref_dev = r.dev_id;
					end
					tbl_ts[k] = r.dev_time_us;
					tbl_seen[k] = r.now_seconds;
					tbl_act[k] = 1'b1;
					o.status = dtot_pkg::ST_OK;
				end
			end
			dtot_pkg::ACT_SET_REF: begin
				k = find_dev(r.dev_id);
				if (k < 0) o.status = dtot_pkg::ST_NOT_FND;
				else ref_dev = r.dev_id;
			end
			dtot_pkg::ACT_CALC: begin
				k = (ref_dev == 0) ? -1 : find_dev(ref_dev);
				if (ref_dev == 0) begin
					o.status = dtot_pkg::ST_NO_REF;
				end else if (k < 0 || !tbl_act[k]) begin
					o.status = dtot_pkg::ST_REF_IDLE;
				end else begin
					rts = tbl_ts[k];
					act_n = 0; others = 0;
					mx = dtot_pkg::SIGN64; mn = ~dtot_pkg::SIGN64; sum = '0;
					for (int i = 0; i < tbl_used; i++) begin
						if (!tbl_act[i]) continue;
						act_n++;
						if (tbl_id[i] == ref_dev) begin
							tbl_off[i] = '0;
							continue;
						end
						off = rts - tbl_ts[i];
						tbl_off[i] = off;
						if ($signed(off) > $signed(mx)) mx = off;
						if ($signed(off) < $signed(mn)) mn = off;
						sum += off;
						others++;
					end
					s_active = act_n[4:0];
					if (others == 0) begin
						s_max = '0; s_min = '0; s_avg = '0;
					end else begin
						s_max = mx; s_min = mn;
						if (sum[63]) begin
							q = (64'd0 - sum) / 64'(others);
							s_avg = 64'd0 - q;
						end else begin
							s_avg = sum / 64'(others);
						end
					end
					s_cycles++;
				end
			end
			dtot_pkg::ACT_GET: begin
				k = find_dev(r.dev_id);
				if (k < 0) o.status = dtot_pkg::ST_NOT_FND;
				else o.offset_us = tbl_off[k];
			end
			dtot_pkg::ACT_TIMEOUT: begin
				for (int i = 0; i < tbl_used; i++) begin
					if (!tbl_act[i] || r.now_seconds < tbl_seen[i]) continue;
					if (r.now_seconds - tbl_seen[i] > {16'd0, timeout_lim}) begin
						tbl_act[i] = 1'b0;
						o.timeouts_found++;
					end
				end
			end
			default: ;
		endcase
		o.off_max = s_max;
		o.off_min = s_min;
		o.off_mean = s_avg;
		o.live_count = s_active;
		o.entry_count = tbl_used[4:0];
		o.calc_cycles = s_cycles;
		return o;
	endfunction

	// request handshake seen at the rising edge
	always @(posedge clk) begin
		req_fire <= arst_n && req.valid && req.ready;
	end

	// driver
	always @(negedge clk) begin
		if (req_fire) begin
			expected_rsps.push_back(table_apply({req.action, req.dev_id,
				req.dev_time_us, req.now_seconds}));
			pending_reqs.pop_front();
		end
		if (!arst_n) begin
			req.valid <= 1'b0;
		end else if (req_gap > 0) begin
			req_gap--;
			req.valid <= 1'b0;
		end else if (pending_reqs.size() > 0) begin
			if (!quiet && (!req.valid || req_fire) && $urandom_range(0, 9) == 0) begin
				req_gap = $urandom_range(0, 16);
				req.valid <= 1'b0;
			end else begin
				req.valid <= 1'b1;
				{req.action, req.dev_id, req.dev_time_us, req.now_seconds}
					<= pending_reqs[0];
			end
		end else begin
			req.valid <= 1'b0;
		end
	end

	// sink stalls
	always @(negedge clk) begin
		if (!arst_n) begin
			rsp.ready <= 1'b0;
		end else if (rsp_gap > 0) begin
			rsp_gap--;
			rsp.ready <= 1'b0;
		end else if (!quiet && $urandom_range(0, 9) == 0) begin
			rsp_gap = $urandom_range(0, 16);
			rsp.ready <= 1'b0;
		end else begin
			rsp.ready <= 1'b1;
		end
	end

	// monitor
	always @(posedge clk) begin
		dtot_tb_pkg::dtot_rsp_t got, want;
		if (arst_n) begin
			if ((req.valid && req.ready) || (rsp.valid && rsp.ready)) stall_cnt <= 0;
			else stall_cnt <= stall_cnt + 1;
			if (rsp.valid && rsp.ready) begin
				got = {rsp.status, rsp.offset_us, rsp.off_max, rsp.off_min,
					rsp.off_mean, rsp.live_count, rsp.entry_count,
					rsp.timeouts_found, rsp.calc_cycles};
				if (expected_rsps.size() == 0) begin
					$display("%0t: unexpected transaction %h", $time, got);
					errors++;
				end else begin
					want = expected_rsps.pop_front();
					if (got !== want) begin
						$display("%0t: mismatch expected %h actual %h", $time, want, got);
						errors++;
					end
				end
			end
			if (stall_cnt >= STALL_LIMIT) begin
				$display("** device_time_offset_table_core: FAILED **");
				$finish;
			end
		end
	end

	task automatic wait_drained();
		while (pending_reqs.size() > 0 || expected_rsps.size() > 0 || req.valid)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_timeout(logic [15:0] v);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(negedge clk);
		cfg_we <= 1'b0;
		timeout_lim = v;
	endtask

	function automatic dtot_tb_pkg::dtot_req_t mk(logic [2:0] a, logic [31:0] id,
		logic [63:0] ts, logic [31:0] now);
		return {a, id, ts, now};
	endfunction

	// ids from a small pool so lookups hit often
	function automatic logic [31:0] pick_id();
		case ($urandom_range(0, 5))
			0: return $urandom;
			1: return 32'd0;
			default: return 32'(100 + $urandom_range(0, 19));
		endcase
	endfunction

	function automatic logic [63:0] pick_ts();
		case ($urandom_range(0, 3))
			0: return {$urandom, $urandom};
			1: return 64'hFFFF_FFFF_FFFF_FF00 + 64'($urandom_range(0, 255));
			default: return 64'd1_000_000 + 64'($urandom_range(0, 50000));
		endcase
	endfunction

	initial begin
		logic [31:0] now;
		req.valid = 1'b0;
		req.action = '0;
		req.dev_id = '0;
		req.dev_time_us = '0;
		req.now_seconds = '0;
		rsp.ready = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		errors = 0; stall_cnt = 0; quiet = 0; req_gap = 0; rsp_gap = 0;
		for (int i = 0; i < dtot_pkg::MAX_DEVICES; i++) begin
			tbl_id[i] = '0; tbl_ts[i] = '0; tbl_off[i] = '0;
			tbl_act[i] = 1'b0; tbl_seen[i] = '0;
		end
		tbl_used = 0; ref_dev = '0;
		s_max = '0; s_min = '0; s_avg = '0; s_active = '0; s_cycles = '0;
		timeout_lim = 16'd5;
		arst_n = 1'b0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: no reference, id zero, extremes, full table, clock going backwards
		pending_reqs.push_back(mk(dtot_pkg::ACT_CALC, 0, 0, 0));
		pending_reqs.push_back(mk(dtot_pkg::ACT_GET, 32'd7, 0, 0));
		pending_reqs.push_back(mk(dtot_pkg::ACT_UPDATE, 32'd0, '1, 32'd10));
		pending_reqs.push_back(mk(dtot_pkg::ACT_SET_REF, 32'd0, 0, 0));
		pending_reqs.push_back(mk(dtot_pkg::ACT_CALC, 0, 0, 0));
		pending_reqs.push_back(mk(dtot_pkg::ACT_UPDATE, '1, 64'd5, 32'd10));
		pending_reqs.push_back(mk(dtot_pkg::ACT_CALC, 0, 0, 0));
		pending_reqs.push_back(mk(dtot_pkg::ACT_UPDATE, 32'd1, 64'h8000_0000_0000_0000, '1));
		pending_reqs.push_back(mk(dtot_pkg::ACT_CALC, 0, 0, 0));
		pending_reqs.push_back(mk(dtot_pkg::ACT_GET, 32'd1, 0, 0));
		pending_reqs.push_back(mk(dtot_pkg::ACT_SET_REF, 32'd9, 0, 0));
		pending_reqs.push_back(mk(dtot_pkg::ACT_TIMEOUT, 0, 0, 32'd5));
		pending_reqs.push_back(mk(dtot_pkg::ACT_TIMEOUT, 0, 0, 32'd16));
		pending_reqs.push_back(mk(dtot_pkg::ACT_CALC, 0, 0, 0));
		pending_reqs.push_back(mk(3'd5, '1, '1, '1));
		pending_reqs.push_back(mk(3'd7, 0, 0, 0));
		for (int i = 0; i < 16; i++)
			pending_reqs.push_back(mk(dtot_pkg::ACT_UPDATE, 32'(200 + i), 64'(i * 3), 32'd20));
		pending_reqs.push_back(mk(dtot_pkg::ACT_SET_REF, 32'd200, 0, 0));
		pending_reqs.push_back(mk(dtot_pkg::ACT_CALC, 0, 0, 0));
		pending_reqs.push_back(mk(dtot_pkg::ACT_GET, 32'd215, 0, 0));
		wait_drained();

		// random phases; each phase starts by writing a new timeout limit
		for (int ph = 0; ph < 6; ph++) begin
			case (ph)
				0: write_timeout(16'd0);
				1: write_timeout(16'hFFFF);
				default: write_timeout(16'($urandom_range(1, 30)));
			endcase
			quiet = (ph == 5);
			now = $urandom_range(0, 1000);
			if (ph == 2) now = 32'hFFFF_FFF0;
			for (int n = 0; n < 325; n++) begin
				dtot_tb_pkg::dtot_req_t r;
				if ($urandom_range(0, 3) == 0) now += $urandom_range(0, 6);
				r.dev_id = pick_id();
				r.dev_time_us = pick_ts();
				r.now_seconds = ($urandom_range(0, 19) == 0) ? $urandom : now;
				case ($urandom_range(0, 19))
					0, 1, 2, 3, 4, 5, 6, 7: r.action = dtot_pkg::ACT_UPDATE;
					8, 9: r.action = dtot_pkg::ACT_SET_REF;
					10, 11, 12, 13: r.action = dtot_pkg::ACT_CALC;
					14, 15, 16: r.action = dtot_pkg::ACT_GET;
					17, 18: r.action = dtot_pkg::ACT_TIMEOUT;
					default: r.action = 3'($urandom_range(5, 7));
				endcase
				pending_reqs.push_back(r);
				// sender holds off until the table is idle
				if (n == 160) wait_drained();
			end
			wait_drained();
		end

		if (errors == 0)
			$display("** device_time_offset_table_core: PASSED **");
		else
			$display("** device_time_offset_table_core: FAILED **");
		$finish;
	end
endmodule
